// ----- hw/rtl/fw2d_pkg.sv -----
// ----------------------------------------------------------------------------
// fw2d_pkg
// Shared types, sizes and helpers of the two-dimensional Fenwick tree block.
// ----------------------------------------------------------------------------
package fw2d_pkg;

  localparam int MAX_ROWS = 64;
  localparam int MAX_COLS = 64;
  localparam int IDX_W    = 7;
  localparam int DELTA_W  = 32;
  localparam int SUM_W    = 64;
  localparam int ROW_AW   = $clog2(MAX_ROWS);
  localparam int COL_AW   = $clog2(MAX_COLS);
  localparam int ADDR_W   = ROW_AW + COL_AW;
  localparam int DEPTH    = MAX_ROWS * MAX_COLS;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W   = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W   = $clog2(QUEUE_DEPTH + 1);

  localparam logic REG_ROWS = 1'b0;
  localparam logic REG_COLS = 1'b1;

  localparam logic CMD_QUERY  = 1'b0;
  localparam logic CMD_UPDATE = 1'b1;

  localparam logic [1:0] PFX_LAST = 2'd3;

  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [IDX_W:0]   walk_t;

  typedef enum logic [1:0] {
    JOB_QUERY,
    JOB_UPDATE,
    JOB_ERROR
  } job_kind_t;

  typedef struct packed {
    job_kind_t                  kind;
    idx_t                       row_lo;
    idx_t                       col_lo;
    idx_t                       row_hi;
    idx_t                       col_hi;
    logic signed [DELTA_W-1:0]  delta;
    idx_t                       nr;
    idx_t                       nc;
  } job_t;

  typedef enum logic [2:0] {
    B_CLEAR,
    B_IDLE,
    B_PREP,
    B_QRD,
    B_QWAIT,
    B_URD,
    B_UWR,
    B_DONE
  } back_state_t;

  function automatic walk_t low_bit(walk_t v);
    return v & (~v + 1'b1);
  endfunction

  function automatic logic [ADDR_W-1:0] cell_addr(walk_t i, walk_t j);
    walk_t ri;
    walk_t cj;
    ri = i - 1'b1;
    cj = j - 1'b1;
    return {ri[ROW_AW-1:0], cj[COL_AW-1:0]};
  endfunction

  function automatic idx_t eff_size(idx_t reg_val, idx_t cap);
    idx_t res;
    if (reg_val == '0) begin
      res = idx_t'(1);
    end else if (reg_val > cap) begin
      res = cap;
    end else begin
      res = reg_val;
    end
    return res;
  endfunction

endpackage

// ----- hw/rtl/fw2d_front.sv -----
// ----------------------------------------------------------------------------
// fw2d_front
// Size registers, item accept and range check; turns each word into a job.
// ----------------------------------------------------------------------------
module fw2d_front
  import fw2d_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [0:0]  cfg_addr,
  input  logic [IDX_W-1:0] cfg_wdata,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,
  input  logic [0:0]  in_tuser,
  input  logic        clear_busy,
  output logic        q_valid,
  input  logic        q_ready,
  output job_t        q_job
);

  idx_t rows_r, rows_nxt;
  idx_t cols_r, cols_nxt;
  idx_t nr, nc;
  idx_t rlo, clo, rhi, chi;
  logic upd_bad, qry_bad;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_r <= idx_t'(MAX_ROWS);
      cols_r <= idx_t'(MAX_COLS);
    end else begin
      rows_r <= rows_nxt;
      cols_r <= cols_nxt;
    end
  end

  always_comb begin
    rows_nxt = rows_r;
    cols_nxt = cols_r;
    if (cfg_wr_en) begin
      unique case (cfg_addr[0])
        REG_ROWS: rows_nxt = cfg_wdata;
        REG_COLS: cols_nxt = cfg_wdata;
        default:  rows_nxt = rows_r;
      endcase
    end
  end

  always_comb begin
    nr  = eff_size(rows_r, idx_t'(MAX_ROWS));
    nc  = eff_size(cols_r, idx_t'(MAX_COLS));
    rlo = in_tdata[6:0];
    clo = in_tdata[13:7];
    rhi = in_tdata[20:14];
    chi = in_tdata[27:21];
    upd_bad = (rlo == '0) || (clo == '0) || (rlo > nr) || (clo > nc);
    qry_bad = (rlo > nr) || (rhi > nr) || (clo > nc) || (chi > nc);
    q_job.row_lo = rlo;
    q_job.col_lo = clo;
    q_job.row_hi = rhi;
    q_job.col_hi = chi;
    q_job.delta  = in_tdata[59:28];
    q_job.nr     = nr;
    q_job.nc     = nc;
    if (in_tuser[0] == CMD_UPDATE) begin
      q_job.kind = upd_bad ? JOB_ERROR : JOB_UPDATE;
    end else begin
      q_job.kind = qry_bad ? JOB_ERROR : JOB_QUERY;
    end
  end

  assign q_valid   = in_tvalid & ~clear_busy;
  assign in_tready = q_ready & ~clear_busy;

endmodule

// ----- hw/rtl/fw2d_queue.sv -----
// ----------------------------------------------------------------------------
// fw2d_queue
// Short job queue between the front and the tree engine.
// ----------------------------------------------------------------------------
module fw2d_queue
  import fw2d_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  wr_valid,
  output logic  wr_ready,
  input  job_t  wr_job,
  output logic  rd_valid,
  input  logic  rd_ready,
  output job_t  rd_job
);

  job_t              slot_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;
  logic              push, pop;

  assign wr_ready = (count_r != QCNT_W'(QUEUE_DEPTH));
  assign rd_valid = (count_r != '0);
  assign rd_job   = slot_r[rd_ptr_r];
  assign push     = wr_valid & wr_ready;
  assign pop      = rd_valid & rd_ready;

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= wr_job;
    end
  end

endmodule

// ----- hw/rtl/fw2d_back.sv -----
// ----------------------------------------------------------------------------
// fw2d_back
// Tree engine: clearing pass, prefix walks, point updates and result register.
// ----------------------------------------------------------------------------
module fw2d_back
  import fw2d_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        q_valid,
  output logic        q_ready,
  input  job_t        q_job,
  output logic        clear_busy,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,
  output logic [0:0]  out_tuser
);

  logic [SUM_W-1:0]  cells [DEPTH];
  logic [SUM_W-1:0]  mem_rdata_r;
  logic              mem_we, mem_re;
  logic [ADDR_W-1:0] mem_waddr, mem_raddr;
  logic [SUM_W-1:0]  mem_wdata;

  back_state_t       state_r, state_nxt;
  job_t              job_r, job_nxt;
  logic [ADDR_W-1:0] clr_cnt_r, clr_cnt_nxt;
  logic [1:0]        pfx_r, pfx_nxt;
  walk_t             i_r, i_nxt;
  walk_t             j_r, j_nxt;
  walk_t             cbase_r, cbase_nxt;
  logic [SUM_W-1:0]  acc_r, acc_nxt;
  logic              rd_vld_r, rd_vld_nxt;
  logic              rd_neg_r, rd_neg_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [SUM_W-1:0]  out_total_r, out_total_nxt;
  logic              out_status_r, out_status_nxt;

  idx_t              ra, cb, pr, pc;
  walk_t             i_step, j_step;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      cells[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_rdata_r <= cells[mem_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_CLEAR;
      clr_cnt_r   <= '0;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      rd_vld_r    <= rd_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    job_r        <= job_nxt;
    pfx_r        <= pfx_nxt;
    i_r          <= i_nxt;
    j_r          <= j_nxt;
    cbase_r      <= cbase_nxt;
    acc_r        <= acc_nxt;
    rd_neg_r     <= rd_neg_nxt;
    out_total_r  <= out_total_nxt;
    out_status_r <= out_status_nxt;
  end

  always_comb begin
    ra = (job_r.row_lo == '0) ? '0 : job_r.row_lo - 1'b1;
    cb = (job_r.col_lo == '0) ? '0 : job_r.col_lo - 1'b1;
    case (pfx_r)
      2'd0:    begin pr = job_r.row_hi; pc = job_r.col_hi; end
      2'd1:    begin pr = job_r.row_hi; pc = cb;           end
      2'd2:    begin pr = ra;           pc = job_r.col_hi; end
      default: begin pr = ra;           pc = cb;           end
    endcase
  end

  always_comb begin
    state_nxt      = state_r;
    job_nxt        = job_r;
    clr_cnt_nxt    = clr_cnt_r;
    pfx_nxt        = pfx_r;
    i_nxt          = i_r;
    j_nxt          = j_r;
    cbase_nxt      = cbase_r;
    rd_vld_nxt     = 1'b0;
    rd_neg_nxt     = rd_neg_r;
    out_total_nxt  = out_total_r;
    out_status_nxt = out_status_r;
    out_valid_nxt  = out_tready ? 1'b0 : out_valid_r;
    mem_we         = 1'b0;
    mem_waddr      = '0;
    mem_wdata      = '0;
    mem_re         = 1'b0;
    mem_raddr      = '0;
    q_ready        = 1'b0;
    i_step         = '0;
    j_step         = '0;

    acc_nxt = acc_r;
    if (rd_vld_r) begin
      acc_nxt = rd_neg_r ? acc_r - mem_rdata_r : acc_r + mem_rdata_r;
    end

    unique case (state_r)
      B_CLEAR: begin
        mem_we      = 1'b1;
        mem_waddr   = clr_cnt_r;
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (clr_cnt_r == '1) begin
          state_nxt = B_IDLE;
        end
      end
      B_IDLE: begin
        q_ready = 1'b1;
        if (q_valid) begin
          job_nxt   = q_job;
          acc_nxt   = '0;
          pfx_nxt   = '0;
          i_nxt     = {1'b0, q_job.row_lo};
          j_nxt     = {1'b0, q_job.col_lo};
          unique case (q_job.kind)
            JOB_QUERY:  state_nxt = B_PREP;
            JOB_UPDATE: state_nxt = B_URD;
            default:    state_nxt = B_DONE;
          endcase
        end
      end
      B_PREP: begin
        if (pr == '0 || pc == '0) begin
          if (pfx_r == PFX_LAST) begin
            state_nxt = B_QWAIT;
          end else begin
            pfx_nxt = pfx_r + 1'b1;
          end
        end else begin
          i_nxt     = {1'b0, pr};
          j_nxt     = {1'b0, pc};
          cbase_nxt = {1'b0, pc};
          state_nxt = B_QRD;
        end
      end
      B_QRD: begin
        mem_re     = 1'b1;
        mem_raddr  = cell_addr(i_r, j_r);
        rd_vld_nxt = 1'b1;
        rd_neg_nxt = (pfx_r == 2'd1) || (pfx_r == 2'd2);
        j_step     = j_r - low_bit(j_r);
        i_step     = i_r - low_bit(i_r);
        if (j_step != '0) begin
          j_nxt = j_step;
        end else begin
          j_nxt = cbase_r;
          if (i_step != '0) begin
            i_nxt = i_step;
          end else if (pfx_r == PFX_LAST) begin
            state_nxt = B_QWAIT;
          end else begin
            pfx_nxt   = pfx_r + 1'b1;
            state_nxt = B_PREP;
          end
        end
      end
      B_QWAIT: begin
        state_nxt = B_DONE;
      end
      B_URD: begin
        mem_re    = 1'b1;
        mem_raddr = cell_addr(i_r, j_r);
        state_nxt = B_UWR;
      end
      B_UWR: begin
        mem_we    = 1'b1;
        mem_waddr = cell_addr(i_r, j_r);
        mem_wdata = mem_rdata_r + {{(SUM_W-DELTA_W){job_r.delta[DELTA_W-1]}}, job_r.delta};
        j_step    = j_r + low_bit(j_r);
        i_step    = i_r + low_bit(i_r);
        state_nxt = B_URD;
        if (j_step <= {1'b0, job_r.nc}) begin
          j_nxt = j_step;
        end else begin
          j_nxt = {1'b0, job_r.col_lo};
          if (i_step <= {1'b0, job_r.nr}) begin
            i_nxt = i_step;
          end else begin
            state_nxt = B_DONE;
          end
        end
      end
      B_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt  = 1'b1;
          out_total_nxt  = (job_r.kind == JOB_QUERY) ? acc_r : '0;
          out_status_nxt = (job_r.kind == JOB_ERROR);
          state_nxt      = B_IDLE;
        end
      end
      default: state_nxt = B_IDLE;
    endcase
  end

  assign clear_busy = (state_r == B_CLEAR);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_total_r;
  assign out_tuser  = out_status_r;

endmodule

// ----- hw/rtl/fenwick_2d_rectangle_sum.sv -----
// ----------------------------------------------------------------------------
// fenwick_2d_rectangle_sum
// Two-dimensional Fenwick tree of 64-bit sums: point updates, rectangle sums.
// ----------------------------------------------------------------------------
// After reset the block runs a clearing pass over all 4096 cells of the cell
// memory and takes no word until it ends; size writes are taken throughout.
// One item is worked at a time from a cell memory with one read port and one
// write port that serves one read or one write a cycle. A query reads up to
// four prefix walks of 6 by 6 cells, one cell a cycle, with one set-up step
// per prefix, then B_QWAIT and B_DONE to finish. An update reads and then
// writes each cell it touches. An item out of range goes from idle straight
// to the result state. A two-deep job queue lets words be taken while the
// engine works and a result waits in its register.
// ----------------------------------------------------------------------------
module fenwick_2d_rectangle_sum
  import fw2d_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_wr_en,
  input  logic [0:0]       cfg_addr,
  input  logic [IDX_W-1:0] cfg_wdata,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [63:0]      in_tdata,   // row_lo, col_lo, row_hi, col_hi, delta, zero pad
  input  logic [0:0]       in_tuser,   // cmd
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [63:0]      out_tdata,  // total
  output logic [0:0]       out_tuser   // status
);

  logic fq_valid, fq_ready;
  job_t fq_job;
  logic qb_valid, qb_ready;
  job_t qb_job;
  logic clear_busy;

  fw2d_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .clear_busy (clear_busy),
    .q_valid    (fq_valid),
    .q_ready    (fq_ready),
    .q_job      (fq_job)
  );

  fw2d_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (fq_valid),
    .wr_ready (fq_ready),
    .wr_job   (fq_job),
    .rd_valid (qb_valid),
    .rd_ready (qb_ready),
    .rd_job   (qb_job)
  );

  fw2d_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (qb_valid),
    .q_ready    (qb_ready),
    .q_job      (qb_job),
    .clear_busy (clear_busy),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule
